FILE: sv/swm_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window maximum package
// Shared constants and the control bundle broadcast to every candidate cell.
// ----------------------------------------------------------------------------
package swm_pkg;

	localparam int REG_W = 9;
	localparam int OUT_W = 32;
	localparam logic [REG_W-1:0] WIN_LEN_RESET = 9'd250;

	typedef struct packed {
		logic step;
		logic drop;
		logic clear;
	} swm_ctrl_t;

endpackage

FILE: sv/swm_cell.sv
// ----------------------------------------------------------------------------
// Candidate cell
// One entry of the monotonic candidate queue; shifts toward the head on expiry.
// ----------------------------------------------------------------------------
module swm_cell import swm_pkg::*; #(
	parameter int VAL_W = 32,
	parameter int AGE_W = 9,
	parameter int AGE_MAX = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  swm_ctrl_t        ctrl,
	input  logic [VAL_W-1:0] sample,
	input  logic             next_live,
	input  logic [VAL_W-1:0] next_val,
	input  logic [AGE_W-1:0] next_age,
	input  logic             prev_keep,
	output logic             keep,
	output logic             live,
	output logic [VAL_W-1:0] val,
	output logic [AGE_W-1:0] age,
	output logic [VAL_W-1:0] upd_val
);

	logic             live_q;
	logic [VAL_W-1:0] val_q;
	logic [AGE_W-1:0] age_q;
	logic             src_live;
	logic [VAL_W-1:0] src_val;
	logic [AGE_W-1:0] src_age;
	logic [AGE_W-1:0] age_inc;
	logic             place;
	logic             upd_live;
	logic [AGE_W-1:0] upd_age;

	always_comb begin
		src_live = ctrl.drop ? next_live : live_q;
		src_val  = ctrl.drop ? next_val : val_q;
		src_age  = ctrl.drop ? next_age : age_q;
		age_inc  = (src_age == AGE_W'(AGE_MAX)) ? src_age : src_age + AGE_W'(1);
		keep     = src_live && (src_val > sample);
		place    = !keep && prev_keep;
		upd_live = keep || place;
		upd_val  = keep ? src_val : sample;
		upd_age  = keep ? age_inc : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= 1'b0;
		end else if (ctrl.clear) begin
			live_q <= 1'b0;
		end else if (ctrl.step) begin
			live_q <= upd_live;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.step && !ctrl.clear) begin
			val_q <= upd_val;
			age_q <= upd_age;
		end
	end

	assign live = live_q;
	assign val  = val_q;
	assign age  = age_q;

endmodule

FILE: sv/sliding_window_maximum.sv
// ----------------------------------------------------------------------------
// Sliding window maximum
// Running peak of the most recent window_length samples of a stream.
// ----------------------------------------------------------------------------
// Each request on the slave channel carries one unsigned sample. Each one
// yields one request on the master channel: the largest of the most recent
// window_length samples and a valid flag in tuser. Until window_length
// samples have been seen, the flag is low and the maximum reads zero.
// The candidates live in a row of WINDOW_MAX cells, every cell updating in
// the same cycle from its own entry and its neighbor's, so a new sample is
// taken in every cycle unless a result waits on a stalled receiver. Each
// result is in the output register the cycle after its sample; a stalled
// receiver holds it there; the next sample is taken in the cycle it leaves.
// Reset empties the queue and restores a window length of 250. A write to
// the configuration register sets the length, empties the queue and starts
// the warm-up again; write it only while no request is in flight. A length
// of zero acts as one and a length above WINDOW_MAX acts as WINDOW_MAX.
// ----------------------------------------------------------------------------
module sliding_window_maximum import swm_pkg::*; #(
	parameter int WINDOW_MAX = 256,
	parameter int SAMPLE_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [REG_W-1:0]                    cfg_wdata,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// Fields from bit 0: sample_value.
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// Fields from bit 0: window_max.
	output logic [OUT_W-1:0]                    m_tdata,
	// Fields from bit 0: max_valid.
	output logic                                m_tuser
);

	localparam int AGE_W = $clog2(WINDOW_MAX + 1);
	localparam int CMP_W = (AGE_W > REG_W) ? AGE_W : REG_W;

	logic [REG_W-1:0]       win_len_q;
	logic [AGE_W-1:0]       seen_q;
	logic                   out_valid_q;
	logic [OUT_W-1:0]       out_max_q;
	logic                   out_flag_q;

	logic [CMP_W-1:0]       len_raw;
	logic [CMP_W-1:0]       len_eff;
	logic [SAMPLE_BITS-1:0] sample;
	logic [AGE_W-1:0]       head_age_inc;
	logic [AGE_W-1:0]       seen_upd;
	logic                   flag_upd;
	swm_ctrl_t              ctrl;

	logic                   live_w [WINDOW_MAX+1];
	logic [SAMPLE_BITS-1:0] val_w  [WINDOW_MAX+1];
	logic [AGE_W-1:0]       age_w  [WINDOW_MAX+1];
	logic                   keep_w [WINDOW_MAX+1];
	logic [SAMPLE_BITS-1:0] upd_val_w [WINDOW_MAX];
	logic [WINDOW_MAX-1:0]  live_vec;

	assign sample   = s_tdata[SAMPLE_BITS-1:0];
	assign s_tready = !out_valid_q || m_tready;

	always_comb begin
		len_raw = CMP_W'(win_len_q);
		if (len_raw == '0) begin
			len_eff = CMP_W'(1);
		end else if (len_raw > CMP_W'(WINDOW_MAX)) begin
			len_eff = CMP_W'(WINDOW_MAX);
		end else begin
			len_eff = len_raw;
		end
		head_age_inc = (age_w[0] == AGE_W'(WINDOW_MAX)) ? age_w[0] : age_w[0] + AGE_W'(1);
		seen_upd     = (seen_q == AGE_W'(WINDOW_MAX)) ? seen_q : seen_q + AGE_W'(1);
		flag_upd     = CMP_W'(seen_upd) >= len_eff;
		ctrl.clear   = cfg_we;
		ctrl.step    = s_tvalid && s_tready;
		ctrl.drop    = live_w[0] && (CMP_W'(head_age_inc) >= len_eff);
	end

	assign live_w[WINDOW_MAX] = 1'b0;
	assign val_w[WINDOW_MAX]  = '0;
	assign age_w[WINDOW_MAX]  = '0;
	assign keep_w[0]          = 1'b1;

	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		swm_cell #(
			.VAL_W   (SAMPLE_BITS),
			.AGE_W   (AGE_W),
			.AGE_MAX (WINDOW_MAX)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.sample    (sample),
			.next_live (live_w[i+1]),
			.next_val  (val_w[i+1]),
			.next_age  (age_w[i+1]),
			.prev_keep (keep_w[i]),
			.keep      (keep_w[i+1]),
			.live      (live_w[i]),
			.val       (val_w[i]),
			.age       (age_w[i]),
			.upd_val   (upd_val_w[i])
		);
		assign live_vec[i] = live_w[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q   <= WIN_LEN_RESET;
			seen_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				win_len_q <= cfg_wdata;
				seen_q    <= '0;
			end else if (ctrl.step) begin
				seen_q <= seen_upd;
			end
			if (ctrl.step) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.step) begin
			out_max_q  <= flag_upd ? OUT_W'(upd_val_w[0]) : '0;
			out_flag_q <= flag_upd;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_max_q;
	assign m_tuser  = out_flag_q;

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !live_w[0])
		else $error("Queue not empty after a register write.");

	a_live_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot({1'b0, live_vec} + {{WINDOW_MAX{1'b0}}, 1'b1}))
		else $error("Live candidates do not form a prefix.");

	a_warmup_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == '0))
		else $error("Nonzero maximum during warm-up.");

	a_request_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> m_tvalid)
		else $error("Accepted sample produced no result.");

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// Sliding window maximum testbench
// Streams samples through the block under several window lengths and checks
// every result against a deque-based peak tracker kept in the testbench.
// Both stream sides idle at random. One phase stalls the receiver for a long
// stretch, and another drains all results before more samples are sent.
// ----------------------------------------------------------------------------
module testbench import swm_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WINDOW_MAX = 256;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 150;
	localparam int SETTLE_CYCLES = 4;
	localparam int IDLE_PCT = 36;

	typedef enum {MIX_FULL, MIX_TIES, MIX_FALL, MIX_WALK} sample_mix_t;

	typedef struct packed {
		logic [OUT_W-1:0] window_max;
		logic             max_valid;
	} peak_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [REG_W-1:0] cfg_wdata = '0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [31:0]      s_tdata = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic             m_tuser;

	logic [REG_W-1:0] win_len = WIN_LEN_RESET;
	logic [31:0]      cand_vals[$];
	int               cand_ages[$];
	int               seen_cnt = 0;
	peak_t            max_due[$];

	logic no_idle = 1'b0;
	int   hold_ask = 0;
	int   hold_seen = 0;
	int   hold_left = 0;
	int   bad = 0;
	int   got = 0;
	int   cycles = 0;

	sliding_window_maximum #(
		.WINDOW_MAX(WINDOW_MAX),
		.SAMPLE_BITS(32)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Candidates are kept oldest first with strictly falling values.
	function automatic peak_t track_peak(logic [31:0] smp);
		int    len;
		peak_t r;
		len = (win_len == 0) ? 1 : ((int'(win_len) > WINDOW_MAX) ? WINDOW_MAX : int'(win_len));
		foreach (cand_ages[i])
			if (cand_ages[i] < WINDOW_MAX)
				cand_ages[i]++;
		while (cand_ages.size() > 0 && cand_ages[0] >= len) begin
			cand_vals.delete(0);
			cand_ages.delete(0);
		end
		while (cand_vals.size() > 0 && cand_vals[$] <= smp) begin
			cand_vals.delete(cand_vals.size() - 1);
			cand_ages.delete(cand_ages.size() - 1);
		end
		if (cand_vals.size() < WINDOW_MAX) begin
			cand_vals.insert(cand_vals.size(), smp);
			cand_ages.insert(cand_ages.size(), 0);
		end
		if (seen_cnt < WINDOW_MAX)
			seen_cnt++;
		r.max_valid = (seen_cnt >= len);
		r.window_max = r.max_valid ? cand_vals[0] : '0;
		return r;
	endfunction

	task automatic send_sample(input logic [31:0] smp);
		if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
		end
		s_tvalid <= 1'b1;
		s_tdata <= smp;
		do @(posedge clk); while (!s_tready);
		max_due.insert(max_due.size(), track_peak(smp));
	endtask

	task automatic drain_results;
		s_tvalid <= 1'b0;
		do @(posedge clk); while (max_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_window(input logic [REG_W-1:0] len);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= len;
		@(posedge clk);
		cfg_we <= 1'b0;
		win_len = len;
		cand_vals.delete();
		cand_ages.delete();
		seen_cnt = 0;
	endtask

	task automatic send_burst(input int count, input sample_mix_t mix);
		logic [31:0] level;
		level = $urandom | 32'hC000_0000;
		for (int i = 0; i < count; i++) begin
			case (mix)
				MIX_FULL: level = $urandom;
				MIX_TIES: level = $urandom_range(3);
				MIX_FALL: level = level - $urandom_range(3);
				MIX_WALK: level = level + $urandom_range(64) - 32;
			endcase
			send_sample(level);
		end
	endtask

	task automatic test_default_length;
		send_burst(150, MIX_WALK);
		send_burst(120, MIX_FULL);
	endtask

	task automatic test_directed;
		logic [31:0] steps[$] = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'd5, 32'd5,
			32'd5, 32'd9, 32'd8, 32'd7, 32'd6, 32'd1, 32'd2, 32'd3, 32'd4,
			32'hAAAA_AAAA, 32'h5555_5555};
		write_window(9'd3);
		send_sample(32'hFFFF_FFFF);
		send_sample(32'h0);
		// A second write in the middle of the warm-up starts it over.
		write_window(9'd3);
		foreach (steps[i])
			send_sample(steps[i]);
		// A zero length behaves as a length of one.
		write_window(9'd0);
		send_sample(32'h0);
		send_sample(32'hFFFF_FFFF);
		send_sample(32'd5);
		send_sample(32'd3);
		send_sample(32'd9);
	endtask

	task automatic test_window_lengths;
		write_window(9'd1);
		send_burst(40, MIX_FULL);
		write_window(9'd2);
		send_burst(40, MIX_TIES);
		// A long falling ramp with ties keeps many candidates live at the largest length.
		write_window(9'd511);
		send_burst(270, MIX_FALL);
		send_burst(10, MIX_FULL);
		write_window(9'd257);
		send_burst(30, MIX_WALK);
		for (int p = 0; p < 4; p++) begin
			write_window(REG_W'($urandom_range(24, 3)));
			send_burst(60, sample_mix_t'($urandom_range(3)));
		end
	endtask

	task automatic test_backpressure;
		write_window(9'd16);
		no_idle <= 1'b1;
		hold_ask <= hold_ask + 1;
		send_burst(60, MIX_FULL);
		no_idle <= 1'b0;
		drain_results();
		send_burst(40, MIX_WALK);
		no_idle <= 1'b1;
		send_burst(150, MIX_WALK);
		no_idle <= 1'b0;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_length();
		test_directed();
		test_window_lengths();
		test_backpressure();
		drain_results();
		if (bad == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

	always @(posedge clk) begin
		if (hold_ask != hold_seen) begin
			hold_seen = hold_ask;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		peak_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got++;
			if (max_due.size() == 0) begin
				bad++;
				if (bad <= 10)
					$display("result %0d with none expected: max %h valid %b",
						got, m_tdata, m_tuser);
			end else begin
				want = max_due[0];
				max_due.delete(0);
				if (m_tdata !== want.window_max || m_tuser !== want.max_valid) begin
					bad++;
					if (bad <= 10)
						$display("result %0d: expected max %h valid %b, got max %h valid %b",
							got, want.window_max, want.max_valid, m_tdata, m_tuser);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

endmodule
